### hw/rtl/assert_macros.svh
// Assertion helpers used by the RTL controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on a given clock, masked while reset is asserted.
`define AISC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same check on the usual clk_i / rst_ni pair.
`define AISC_ASSERT_CLK(lbl, prop, msg) \
  `AISC_ASSERT(lbl, clk_i, rst_ni, prop, msg)

`endif

### hw/rtl/aisc_pkg.sv
package aisc_pkg;

  // Input item codes
  localparam logic [1:0] ACT_EXEC    = 2'd0;
  localparam logic [1:0] ACT_RESP    = 2'd1;
  localparam logic [1:0] ACT_RESTART = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_DONE  = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;

  // Completion status
  localparam logic [1:0] STS_OK     = 2'd0;
  localparam logic [1:0] STS_HALT   = 2'd1;
  localparam logic [1:0] STS_UNIMPL = 2'd2;
  localparam logic [1:0] STS_FAULT  = 2'd3;

  // Memory access phase
  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_FIRST  = 2'd1;
  localparam logic [1:0] PH_SECOND = 2'd2;

  // Config register indexes
  localparam logic CFG_START_PC = 1'b0;
  localparam logic CFG_START_SP = 1'b1;

  // Decode constants
  localparam logic [31:0] NOP_WORD   = 32'hD503201F;
  localparam logic [5:0]  OP_MOVW    = 6'h25;
  localparam logic [5:0]  OP_ADDI    = 6'h22;
  localparam logic [4:0]  OP_ADR     = 5'h10;
  localparam logic [4:0]  OP_ADDR    = 5'h0B;
  localparam logic [4:0]  OP_LOGIC   = 5'h0A;
  localparam logic [7:0]  OP_BCOND   = 8'h54;
  localparam logic [5:0]  OP_CBZ     = 6'h1A;
  localparam logic [6:0]  OP_BR      = 7'h6B;
  localparam logic [7:0]  OP_EXC     = 8'hD4;
  localparam logic [3:0]  COND_ALWAYS = 4'hF;
  localparam logic [4:0]  REG_ZR     = 5'd31;
  localparam logic [4:0]  REG_LR     = 5'd30;

  typedef enum logic [2:0] {
    ST_IDLE, ST_RD, ST_SH, ST_EX, ST_WR, ST_OUT
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic       cap;
    logic       sh;
    logic       ex;
    logic       wr;
    logic [1:0] slot;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic res;
  } sts_t;

  // One pending register write
  typedef struct packed {
    logic        en;
    logic        sp_ok;
    logic [4:0]  idx;
    logic [63:0] data;
  } wr_t;

  typedef struct packed {
    logic [63:0] r;
    logic [3:0]  nzcv;
  } add_t;

  function automatic logic [63:0] shift_op(logic [63:0] v, logic [1:0] ty,
                                           logic [5:0] amt, logic wide);
    logic [63:0] m;
    logic [63:0] x;
    logic [6:0]  a;
    logic [63:0] r;
    m = wide ? '1 : 64'h0000_0000_FFFF_FFFF;
    x = v & m;
    a = wide ? {1'b0, amt} : {2'b0, amt[4:0]};
    case (ty)
      2'd0: r = (x << a) & m;
      2'd1: r = x >> a;
      2'd2: begin
        if (wide) r = $signed(x) >>> a;
        else      r = {32'b0, 32'($signed(x[31:0]) >>> a[4:0])};
      end
      default: begin
        if (wide) r = (x >> a) | (x << (7'd64 - a));
        else      r = {32'b0, (x[31:0] >> a[4:0]) | (x[31:0] << (7'd32 - a))};
      end
    endcase
    return r;
  endfunction

  function automatic add_t add_carry(logic [63:0] a, logic [63:0] b, logic cin,
                                     logic wide);
    logic [64:0] s64;
    logic [32:0] s32;
    add_t o;
    logic n, c, v;
    if (wide) begin
      s64 = {1'b0, a} + {1'b0, b} + {64'b0, cin};
      o.r = s64[63:0];
      c = s64[64];
      v = ~(a[63] ^ b[63]) & (a[63] ^ o.r[63]);
      n = o.r[63];
    end else begin
      s32 = {1'b0, a[31:0]} + {1'b0, b[31:0]} + {32'b0, cin};
      o.r = {32'b0, s32[31:0]};
      c = s32[32];
      v = ~(a[31] ^ b[31]) & (a[31] ^ o.r[31]);
      n = o.r[31];
    end
    o.nzcv = {n, o.r == 64'd0, c, v};
    return o;
  endfunction

  function automatic logic cond_holds(logic [3:0] cond, logic [3:0] f);
    logic r;
    case (cond[3:1])
      3'd0: r = f[2];
      3'd1: r = f[1];
      3'd2: r = f[3];
      3'd3: r = f[0];
      3'd4: r = f[1] & ~f[2];
      3'd5: r = (f[3] == f[0]);
      3'd6: r = (f[3] == f[0]) & ~f[2];
      default: r = 1'b1;
    endcase
    if (cond[0] && cond != COND_ALWAYS) r = ~r;
    return r;
  endfunction

endpackage

### hw/rtl/aisc_ram.sv
module aisc_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 31,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_a_i,
  output logic [WIDTH-1:0] rdata_a_o,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write one entry, register both reads
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

### hw/rtl/aisc_ctrl.sv
`include "assert_macros.svh"

module aisc_ctrl import aisc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e     state_q, state_d;
  logic [1:0] slot_q, slot_d;

  // Hold state and write slot counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      slot_q  <= 2'd0;
    end else begin
      state_q <= state_d;
      slot_q  <= slot_d;
    end
  end

  // Sequence capture, operand read, shift, execute, write-back, result
  always_comb begin
    state_d     = state_q;
    slot_d      = slot_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.cap = 1'b1;
          state_d   = ST_RD;
        end
      end
      ST_RD: state_d = ST_SH;
      ST_SH: begin
        cmd_o.sh = 1'b1;
        state_d  = ST_EX;
      end
      ST_EX: begin
        cmd_o.ex = 1'b1;
        slot_d   = 2'd0;
        state_d  = ST_WR;
      end
      ST_WR: begin
        cmd_o.wr   = 1'b1;
        cmd_o.slot = slot_q;
        if (slot_q == 2'd2) state_d = sts_i.res ? ST_OUT : ST_IDLE;
        else slot_d = slot_q + 2'd1;
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  `AISC_ASSERT_CLK(a_no_overlap, out_valid_o |-> !in_ready_o, "input taken while result held")
  `AISC_ASSERT_CLK(a_ex_to_wr, (state_q == ST_EX) |=> (state_q == ST_WR), "execute not followed by write-back")
  `AISC_ASSERT_CLK(a_cap_to_rd, cmd_o.cap |=> (state_q == ST_RD), "capture not followed by read")

endmodule

### hw/rtl/aisc_dp.sv
module aisc_dp import aisc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  input  logic [1:0]  action_i,
  input  logic [31:0] instr_word_i,
  input  logic        fetch_ok_i,
  input  logic [63:0] read_data_i,
  input  logic        access_ok_i,
  output logic [1:0]  kind_o,
  output logic [63:0] access_address_o,
  output logic [63:0] write_data_o,
  output logic [1:0]  size_log2_o,
  output logic [1:0]  status_o,
  output logic [63:0] next_pc_o
);

  // Captured item
  logic [1:0]  act_q;
  logic [31:0] word_q;
  logic        fok_q, aok_q;
  logic [63:0] rdata_q;

  // Architectural state
  logic [63:0] start_pc_q, start_sp_q;
  logic [63:0] pc_q, pc_d, sp_q;
  logic [3:0]  nzcv_q, nzcv_d;
  logic [31:0] held_q, held_d;
  logic [1:0]  phase_q, phase_d;
  logic [63:0] first_q, first_d;
  logic        failed_q, failed_d;
  logic [30:0] vld_q;
  logic        sp_rs;

  // Result and pending writes
  logic        res_q, res_d;
  logic [1:0]  kind_q, kind_d, size_q, size_d, stat_q, stat_d;
  logic [63:0] addr_q, addr_d, wdat_q, wdat_d, npc_q, npc_d;
  wr_t         slot_q [3];
  wr_t         slot_d [3];
  wr_t         wsel;

  // Operands
  logic [31:0] w;
  logic [4:0]  rn, rt, rt2, rm, addr_b;
  logic        cls_reg, sf;
  logic [63:0] ram_a, ram_b, a_gpr, a_sp, b_gpr, opb_q;
  logic        va_q, vb_q;

  // Decode helpers
  logic [63:0] pc4, smask, poff, req_off, req_addr, wb, add_b, mov_imm, mov_v;
  logic [63:0] adr_off, lg_r, b26, b19, cbz_v;
  logic [1:0]  lg;
  logic [2:0]  mode;
  logic        pair, load, sec, sub, pair_hit, ldst_hit;
  add_t        ac;

  assign w       = (act_q == ACT_RESP) ? held_q : word_q;
  assign rn      = w[9:5];
  assign rt      = w[4:0];
  assign rt2     = w[14:10];
  assign rm      = w[20:16];
  assign sf      = w[31];
  assign cls_reg = (w[28:24] == OP_ADDR && !w[21]) || w[28:24] == OP_LOGIC;
  assign addr_b  = (act_q == ACT_RESP) ? rt2 : (cls_reg ? rm : rt);

  aisc_ram #(.WIDTH(64), .DEPTH(31)) u_gpr (
    .clk_i    (clk_i),
    .we_i     (cmd_i.wr && wsel.en && wsel.idx != REG_ZR),
    .waddr_i  (wsel.idx),
    .wdata_i  (wsel.data),
    .raddr_a_i(rn),
    .rdata_a_o(ram_a),
    .raddr_b_i(addr_b),
    .rdata_b_o(ram_b)
  );

  // Register 31 and never-written entries read as zero
  always_ff @(posedge clk_i) begin
    va_q <= (rn != REG_ZR) && vld_q[rn];
    vb_q <= (addr_b != REG_ZR) && vld_q[addr_b];
    if (cmd_i.sh) opb_q <= shift_op(b_gpr, w[23:22], w[15:10], sf);
  end

  assign a_gpr = va_q ? ram_a : 64'd0;
  assign a_sp  = (rn == REG_ZR) ? sp_q : a_gpr;
  assign b_gpr = vb_q ? ram_b : 64'd0;

  // Memory geometry
  assign pair  = !w[28];
  assign lg    = pair ? ((w[31:30] == 2'd2) ? 2'd3 : 2'd2) : w[31:30];
  assign load  = w[22];
  assign mode  = w[25:23];
  assign sec   = (act_q == ACT_RESP);
  assign poff  = {{57{w[21]}}, w[21:15]} << lg;
  always_comb begin
    case (lg)
      2'd0:    smask = 64'h0000_0000_0000_00FF;
      2'd1:    smask = 64'h0000_0000_0000_FFFF;
      2'd2:    smask = 64'h0000_0000_FFFF_FFFF;
      default: smask = '1;
    endcase
  end
  assign req_off  = pair ? (((mode != 3'd1) ? poff : 64'd0) + (sec ? (64'd1 << lg) : 64'd0))
                         : ({52'b0, w[21:10]} << lg);
  assign req_addr = a_sp + req_off;
  assign wb       = a_sp + poff;

  // Arithmetic and immediates
  assign pc4     = pc_q + 64'd4;
  assign sub     = w[30];
  assign add_b   = (w[28:23] == OP_ADDI) ? ({52'b0, w[21:10]} << (w[22] ? 4'd12 : 4'd0))
                                         : opb_q;
  assign ac      = add_carry((w[28:23] == OP_ADDI) ? a_sp : a_gpr,
                             sub ? ~add_b : add_b, sub, sf);
  assign mov_imm = {48'b0, w[20:5]} << {w[22:21], 4'b0};
  always_comb begin
    case (w[30:29])
      2'd0:    mov_v = ~mov_imm;
      2'd2:    mov_v = mov_imm;
      default: mov_v = (b_gpr & ~(64'hFFFF << {w[22:21], 4'b0})) | mov_imm;
    endcase
    case (w[30:29])
      2'd1:    lg_r = a_gpr | opb_q;
      2'd2:    lg_r = a_gpr ^ opb_q;
      default: lg_r = a_gpr & opb_q;
    endcase
    if (!sf) lg_r = {32'b0, lg_r[31:0]};
  end
  assign adr_off  = {{43{w[23]}}, w[23:5], w[30:29]};
  assign b26      = {{36{w[25]}}, w[25:0], 2'b0};
  assign b19      = {{43{w[23]}}, w[23:5], 2'b0};
  assign cbz_v    = sf ? b_gpr : {32'b0, b_gpr[31:0]};
  assign pair_hit = w[29:27] == 3'b101 && !w[26] &&
                    (mode == 3'd1 || mode == 3'd2 || mode == 3'd3);
  assign ldst_hit = w[29:27] == 3'b111 && !w[26] && w[25:24] == 2'b01 && !w[23];

  // Work out the whole effect of the item
  always_comb begin
    res_d    = 1'b0;
    kind_d   = KIND_DONE;
    addr_d   = 64'd0;
    wdat_d   = 64'd0;
    size_d   = 2'd0;
    stat_d   = STS_OK;
    npc_d    = pc_q;
    pc_d     = pc_q;
    sp_rs    = 1'b0;
    nzcv_d   = nzcv_q;
    held_d   = held_q;
    phase_d  = phase_q;
    first_d  = first_q;
    failed_d = failed_q;
    for (int i = 0; i < 3; i++) slot_d[i] = '0;
    unique case (act_q)
      ACT_RESTART: begin
        pc_d     = start_pc_q;
        sp_rs    = 1'b1;
        phase_d  = PH_IDLE;
        failed_d = 1'b0;
      end
      ACT_EXEC: begin
        if (phase_q == PH_IDLE) begin
          res_d = 1'b1;
          if (!fok_q) begin
            stat_d = STS_FAULT;
          end else if (w == NOP_WORD) begin
            pc_d = pc4;
          end else if (w[28:23] == OP_MOVW) begin
            if (w[30:29] == 2'd1 || (!sf && w[22])) stat_d = STS_UNIMPL;
            else begin
              slot_d[0] = '{en: 1'b1, sp_ok: 1'b0, idx: rt,
                            data: sf ? mov_v : {32'b0, mov_v[31:0]}};
              pc_d = pc4;
            end
          end else if (w[28:23] == OP_ADDI) begin
            slot_d[0] = '{en: 1'b1, sp_ok: !w[29], idx: rt, data: ac.r};
            if (w[29]) nzcv_d = ac.nzcv;
            pc_d = pc4;
          end else if (w[28:24] == OP_ADR) begin
            slot_d[0] = '{en: 1'b1, sp_ok: 1'b0, idx: rt,
                          data: sf ? ((pc_q & ~64'hFFF) + (adr_off << 12)) : pc_q + adr_off};
            pc_d = pc4;
          end else if (w[28:24] == OP_ADDR && !w[21]) begin
            if (w[23:22] == 2'd3 || (!sf && w[15])) stat_d = STS_UNIMPL;
            else begin
              slot_d[0] = '{en: 1'b1, sp_ok: 1'b0, idx: rt, data: ac.r};
              if (w[29]) nzcv_d = ac.nzcv;
              pc_d = pc4;
            end
          end else if (w[28:24] == OP_LOGIC) begin
            if (w[21] || (!sf && w[15])) stat_d = STS_UNIMPL;
            else begin
              slot_d[0] = '{en: 1'b1, sp_ok: 1'b0, idx: rt, data: lg_r};
              if (w[30:29] == 2'd3)
                nzcv_d = {sf ? lg_r[63] : lg_r[31], lg_r == 64'd0, 2'b00};
              pc_d = pc4;
            end
          end else if ((pair_hit && !w[30]) || (!pair_hit && ldst_hit)) begin
            held_d   = w;
            phase_d  = PH_FIRST;
            failed_d = 1'b0;
            kind_d   = load ? KIND_READ : KIND_WRITE;
            addr_d   = req_addr;
            wdat_d   = load ? 64'd0 : (b_gpr & smask);
            size_d   = lg;
          end else if (pair_hit) begin
            stat_d = STS_UNIMPL;
          end else if (w[30:26] == 5'h05) begin
            if (sf) slot_d[0] = '{en: 1'b1, sp_ok: 1'b0, idx: REG_LR, data: pc4};
            pc_d = pc_q + b26;
          end else if (w[31:24] == OP_BCOND) begin
            pc_d = cond_holds(w[3:0], nzcv_q) ? pc_q + b19 : pc4;
          end else if (w[30:25] == OP_CBZ) begin
            pc_d = ((cbz_v == 64'd0) != w[24]) ? pc_q + b19 : pc4;
          end else if (w[31:25] == OP_BR) begin
            if (w[24:21] > 4'd2) stat_d = STS_UNIMPL;
            else begin
              if (w[24:21] == 4'd1)
                slot_d[0] = '{en: 1'b1, sp_ok: 1'b0, idx: REG_LR, data: pc4};
              pc_d = a_gpr;
            end
          end else if (w[31:24] == OP_EXC) begin
            stat_d = STS_HALT;
            pc_d   = pc4;
          end else begin
            stat_d = STS_UNIMPL;
          end
          if (kind_d == KIND_DONE) npc_d = pc_d;
        end
      end
      ACT_RESP: begin
        if (phase_q != PH_IDLE) begin
          res_d = 1'b1;
          if (!pair) begin
            phase_d = PH_IDLE;
            if (!aok_q) stat_d = STS_FAULT;
            else begin
              if (load) slot_d[0] = '{en: 1'b1, sp_ok: 1'b0, idx: rt, data: rdata_q & smask};
              pc_d = pc4;
            end
          end else if (phase_q == PH_FIRST) begin
            first_d  = rdata_q & smask;
            failed_d = !aok_q;
            phase_d  = PH_SECOND;
            kind_d   = load ? KIND_READ : KIND_WRITE;
            addr_d   = req_addr;
            wdat_d   = load ? 64'd0 : (b_gpr & smask);
            size_d   = lg;
          end else begin
            phase_d = PH_IDLE;
            if (failed_q || !aok_q) stat_d = STS_FAULT;
            else begin
              if (load) begin
                slot_d[0] = '{en: 1'b1, sp_ok: 1'b0, idx: rt, data: first_q};
                slot_d[1] = '{en: 1'b1, sp_ok: 1'b0, idx: rt2, data: rdata_q & smask};
              end
              if (mode != 3'd2) slot_d[2] = '{en: 1'b1, sp_ok: 1'b1, idx: rn, data: wb};
              pc_d = pc4;
            end
          end
          if (kind_d == KIND_DONE) npc_d = pc_d;
        end
      end
      default: ;
    endcase
  end

  assign wsel = slot_q[cmd_i.slot];

  // Capture item, commit state, drain writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_pc_q <= 64'd0;
      start_sp_q <= 64'd0;
      pc_q       <= 64'd0;
      sp_q       <= 64'd0;
      nzcv_q     <= 4'd0;
      held_q     <= 32'd0;
      phase_q    <= PH_IDLE;
      failed_q   <= 1'b0;
      vld_q      <= '0;
      res_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_START_PC) start_pc_q <= cfg_data_i;
        else                           start_sp_q <= cfg_data_i;
      end
      if (cmd_i.ex) begin
        pc_q     <= pc_d;
        nzcv_q   <= nzcv_d;
        held_q   <= held_d;
        phase_q  <= phase_d;
        failed_q <= failed_d;
        res_q    <= res_d;
        if (sp_rs) sp_q <= start_sp_q;
      end
      if (cmd_i.wr && wsel.en) begin
        if (wsel.idx == REG_ZR) begin
          if (wsel.sp_ok) sp_q <= wsel.data;
        end else begin
          vld_q[wsel.idx] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      act_q   <= action_i;
      word_q  <= instr_word_i;
      fok_q   <= fetch_ok_i;
      rdata_q <= read_data_i;
      aok_q   <= access_ok_i;
    end
    if (cmd_i.ex) begin
      first_q <= first_d;
      kind_q  <= kind_d;
      addr_q  <= addr_d;
      wdat_q  <= wdat_d;
      size_q  <= size_d;
      stat_q  <= stat_d;
      npc_q   <= npc_d;
      for (int i = 0; i < 3; i++) slot_q[i] <= slot_d[i];
    end
  end

  assign sts_o.res        = res_q;
  assign kind_o           = kind_q;
  assign access_address_o = addr_q;
  assign write_data_o     = wdat_q;
  assign size_log2_o      = size_q;
  assign status_o         = stat_q;
  assign next_pc_o        = npc_q;

endmodule

### hw/rtl/aarch64_integer_subset_core_unit.sv
// Channel   Dir  Handshake              Payload
// s_axis    in   s_axis_tvalid/tready   tuser: action; tdata: instr, fetch_ok, read_data, access_ok
// m_axis    out  m_axis_tvalid/tready   tuser: kind; tdata: address, wdata, size, status, next_pc
// cfg       in   cfg_we_i               cfg_idx_i selects start_pc / start_sp, cfg_data_i
//
// The result beat is offered once the accepted input beat has passed register file
// read, operand shift, execute and three write-back slots on the single RAM write port,
// and is held until m_axis_tready; the next input is taken in the cycle after the beat goes.
// One item is in flight at a time; s_axis_tready is low until the result beat goes or the item ends.
// Items that give no result return to idle after the write-back slots.
// Reset is asynchronous, active low; the register file reads zero until written.
module aarch64_integer_subset_core_unit import aisc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [31:0] instr_word, [32] fetch_ok, [96:33] read_data, [97] access_ok
  input  logic [103:0] s_axis_tdata,
  // [1:0] action
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [63:0] access_address, [127:64] write_data, [129:128] size_log2,
  // [131:130] status, [195:132] next_pc
  output logic [199:0] m_axis_tdata,
  // [1:0] kind
  output logic [1:0]   m_axis_tuser,
  input  logic         cfg_we_i,
  input  logic         cfg_idx_i,
  input  logic [63:0]  cfg_data_i
);

  cmd_t        cmd;
  sts_t        sts;
  logic [63:0] addr, wdat, npc;
  logic [1:0]  size, stat;

  aisc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  aisc_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .action_i        (s_axis_tuser),
    .instr_word_i    (s_axis_tdata[31:0]),
    .fetch_ok_i      (s_axis_tdata[32]),
    .read_data_i     (s_axis_tdata[96:33]),
    .access_ok_i     (s_axis_tdata[97]),
    .kind_o          (m_axis_tuser),
    .access_address_o(addr),
    .write_data_o    (wdat),
    .size_log2_o     (size),
    .status_o        (stat),
    .next_pc_o       (npc)
  );

  // Pack the result beat
  assign m_axis_tdata = {4'b0, npc, stat, size, wdat, addr};

endmodule
